### rtl/bcsi_pkg.sv
package bcsi_pkg;

  // defaults for the top-level parameters
  localparam int MAX_CLUSTERS_DEF = 256;
  localparam int MAX_VECTORS_DEF  = 65536;

  // fixed field widths
  localparam int KIND_W   = 2;
  localparam int LABEL_W  = 11;
  localparam int CID_W    = 8;
  localparam int STATUS_W = 2;
  localparam int ROW_W    = 16;
  localparam int START_W  = 17;
  localparam int COUNT_W  = 17;
  localparam int CFG_W    = 9;

  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_COUNT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PLACE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SAT   = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic capture;       // latch the accepted request
    logic ctr_zero;      // rewind sweep counter and running offset
    logic clr_step;      // zero one histogram entry
    logic pre_issue;     // prefix pass: fetch next count
    logic pre_write;     // prefix pass: store start and cursor
    logic acc_rd;        // fetch the entries of the request
    logic commit;        // update tables and load result register
    logic offsets_ready; // starts and cursors hold valid data
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ctr_last;      // sweep counter on the final entry
    logic wr_last;       // prefix pass writing the final entry
  } sts_t;

endpackage

### rtl/bcsi_ctrl.sv
module bcsi_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [bcsi_pkg::KIND_W-1:0]       in_kind,
  input  logic                              out_stall,
  input  bcsi_pkg::sts_t                    sts,
  output logic                              in_stall,
  output logic                              out_valid,
  output bcsi_pkg::cmd_t                    cmd
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLR,
    S_PRE_FIRST,
    S_PRE,
    S_ACC,
    S_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   ready_r, ready_nxt;
  logic   accept;
  logic   out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && (state_r == S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt         = state_r;
    ready_nxt         = ready_r;
    out_valid_nxt     = out_valid_r && out_stall;
    cmd               = '0;
    cmd.offsets_ready = ready_r;
    unique case (state_r)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.ctr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd.capture  = 1'b1;
          cmd.ctr_zero = 1'b1;
          unique case (in_kind)
            bcsi_pkg::KIND_COUNT: state_nxt = S_ACC;
            bcsi_pkg::KIND_PLACE: state_nxt = ready_r ? S_ACC : S_PRE_FIRST;
            bcsi_pkg::KIND_READ:  state_nxt = S_ACC;
            bcsi_pkg::KIND_CLEAR: begin
              state_nxt = S_CLR;
              ready_nxt = 1'b0;
            end
            default: state_nxt = S_ACC;
          endcase
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.ctr_last) begin
          state_nxt = S_COMMIT;
        end
      end
      S_PRE_FIRST: begin
        cmd.pre_issue = 1'b1;
        state_nxt     = S_PRE;
      end
      S_PRE: begin
        cmd.pre_write = 1'b1;
        cmd.pre_issue = !sts.wr_last;
        if (sts.wr_last) begin
          ready_nxt = 1'b1;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc_rd = 1'b1;
        state_nxt  = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
      ready_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ready_r     <= ready_nxt;
    end
  end

endmodule

### rtl/bcsi_dp.sv
module bcsi_dp #(
  parameter int MAX_CLUSTERS = bcsi_pkg::MAX_CLUSTERS_DEF,
  parameter int MAX_VECTORS  = bcsi_pkg::MAX_VECTORS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bcsi_pkg::cmd_t                     cmd,
  output bcsi_pkg::sts_t                     sts,
  input  logic                               cfg_wr_en,
  input  logic [bcsi_pkg::CFG_W-1:0]         cfg_wr_data,
  input  logic [bcsi_pkg::KIND_W-1:0]        in_kind,
  input  logic [bcsi_pkg::LABEL_W-1:0]       in_label,
  input  logic [bcsi_pkg::CID_W-1:0]         in_cluster_id,
  output logic [bcsi_pkg::STATUS_W-1:0]      out_status,
  output logic [bcsi_pkg::ROW_W-1:0]         out_dest_row,
  output logic [bcsi_pkg::START_W-1:0]       out_bucket_base,
  output logic [bcsi_pkg::COUNT_W-1:0]       out_member_count
);

  localparam int VW  = $clog2(MAX_VECTORS + 1);
  localparam int CIW = $clog2(MAX_CLUSTERS);

  localparam logic [VW-1:0]  VEC_MAX  = VW'(MAX_VECTORS);
  localparam logic [CIW-1:0] IDX_LAST = CIW'(MAX_CLUSTERS - 1);

  logic [VW-1:0] cnt_mem [MAX_CLUSTERS];
  logic [VW-1:0] start_mem [MAX_CLUSTERS];
  logic [VW-1:0] cur_mem [MAX_CLUSTERS];

  logic [bcsi_pkg::CFG_W-1:0]    cfg_r;
  logic [bcsi_pkg::KIND_W-1:0]   kind_r;
  logic [bcsi_pkg::LABEL_W-1:0]  label_r;
  logic [bcsi_pkg::CID_W-1:0]    cid_r;

  logic [CIW-1:0] ctr_r;
  logic [CIW-1:0] wr_idx_r;
  logic [VW-1:0]  run_r, run_nxt;

  logic [VW-1:0]  cnt_rd_r;
  logic [VW-1:0]  start_rd_r;
  logic [VW-1:0]  cur_rd_r;

  logic [bcsi_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [bcsi_pkg::ROW_W-1:0]    row_r, row_nxt;
  logic [bcsi_pkg::START_W-1:0]  start_r, start_nxt;
  logic [bcsi_pkg::COUNT_W-1:0]  count_r, count_nxt;

  logic           label_ok, cid_ok;
  logic [CIW-1:0] item_addr;
  logic           cnt_we, cur_we;
  logic [CIW-1:0] cnt_rd_addr, cnt_wr_addr, cur_wr_addr;
  logic [VW-1:0]  cnt_wr_data, cur_wr_data;

  assign sts.ctr_last = (ctr_r == IDX_LAST);
  assign sts.wr_last  = (wr_idx_r == IDX_LAST);

  // negative labels and labels at or beyond either cluster limit are out of range
  assign label_ok = !label_r[bcsi_pkg::LABEL_W-1]
                 && ({1'b0, label_r[9:0]} < {2'b00, cfg_r})
                 && ({22'd0, label_r[9:0]} < 32'(MAX_CLUSTERS));
  assign cid_ok   = ({1'b0, cid_r} < cfg_r)
                 && ({24'd0, cid_r} < 32'(MAX_CLUSTERS));

  assign item_addr = (kind_r == bcsi_pkg::KIND_READ) ? CIW'(cid_r) : CIW'(label_r[9:0]);

  // saturating running offset
  assign run_nxt = (cnt_rd_r >= VEC_MAX - run_r) ? VEC_MAX : run_r + cnt_rd_r;

  // result and table updates
  always_comb begin
    status_nxt  = bcsi_pkg::ST_OK;
    row_nxt     = '0;
    start_nxt   = '0;
    count_nxt   = '0;
    cnt_we      = cmd.clr_step;
    cur_we      = cmd.pre_write;
    cnt_rd_addr = cmd.pre_issue ? ctr_r : item_addr;
    cnt_wr_addr = cmd.clr_step ? ctr_r : item_addr;
    cnt_wr_data = cmd.clr_step ? '0 : cnt_rd_r + VW'(1);
    cur_wr_addr = cmd.pre_write ? wr_idx_r : item_addr;
    cur_wr_data = cmd.pre_write ? run_r : cur_rd_r + VW'(1);
    unique case (kind_r)
      bcsi_pkg::KIND_COUNT: begin
        if (!label_ok) begin
          status_nxt = bcsi_pkg::ST_RANGE;
        end else if (cnt_rd_r >= VEC_MAX) begin
          status_nxt = bcsi_pkg::ST_SAT;
        end else begin
          cnt_we = cmd.clr_step || cmd.commit;
        end
      end
      bcsi_pkg::KIND_PLACE: begin
        if (!label_ok) begin
          status_nxt = bcsi_pkg::ST_RANGE;
        end else if (cur_rd_r >= VEC_MAX) begin
          status_nxt = bcsi_pkg::ST_SAT;
        end else begin
          row_nxt = bcsi_pkg::ROW_W'(cur_rd_r);
          cur_we  = cmd.pre_write || cmd.commit;
        end
      end
      bcsi_pkg::KIND_READ: begin
        if (!cid_ok) begin
          status_nxt = bcsi_pkg::ST_RANGE;
        end else begin
          start_nxt = cmd.offsets_ready ? bcsi_pkg::START_W'(start_rd_r) : '0;
          count_nxt = bcsi_pkg::COUNT_W'(cnt_rd_r);
        end
      end
      bcsi_pkg::KIND_CLEAR: begin
        status_nxt = bcsi_pkg::ST_OK;
      end
      default: status_nxt = bcsi_pkg::ST_OK;
    endcase
  end

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= bcsi_pkg::CFG_RESET;
      ctr_r <= '0;
      run_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      if (cmd.ctr_zero) begin
        ctr_r <= '0;
        run_r <= '0;
      end else begin
        if (cmd.clr_step || cmd.pre_issue) begin
          ctr_r <= ctr_r + CIW'(1);
        end
        if (cmd.pre_write) begin
          run_r <= run_nxt;
        end
      end
    end
  end

  // request and result registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= in_kind;
      label_r <= in_label;
      cid_r   <= in_cluster_id;
    end
    if (cmd.commit) begin
      status_r <= status_nxt;
      row_r    <= row_nxt;
      start_r  <= start_nxt;
      count_r  <= count_nxt;
    end
    if (cmd.pre_issue) begin
      wr_idx_r <= ctr_r;
    end
  end

  // histogram
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wr_addr] <= cnt_wr_data;
    end
    if (cmd.pre_issue || cmd.acc_rd) begin
      cnt_rd_r <= cnt_mem[cnt_rd_addr];
    end
  end

  // start offsets
  always_ff @(posedge clk) begin
    if (cmd.pre_write) begin
      start_mem[wr_idx_r] <= run_r;
    end
    if (cmd.acc_rd) begin
      start_rd_r <= start_mem[item_addr];
    end
  end

  // write cursors
  always_ff @(posedge clk) begin
    if (cur_we) begin
      cur_mem[cur_wr_addr] <= cur_wr_data;
    end
    if (cmd.acc_rd) begin
      cur_rd_r <= cur_mem[item_addr];
    end
  end

  assign out_status       = status_r;
  assign out_dest_row     = row_r;
  assign out_bucket_base  = start_r;
  assign out_member_count = count_r;

endmodule

### rtl/bucket_count_and_scatter_index_top.sv
// count, place and read requests: tables read in S_ACC, result committed in S_COMMIT, one request at a time
// the first place after reset or a clear adds a prefix sweep over every histogram entry
// a clear request sweeps the histogram, one entry a cycle, before its result
// rate is set by the single registered read port of each table and the one-entry-a-cycle sweeps
// synchronous active-low reset; afterwards in_stall stays high while the histogram is zeroed,
// the register resets to 256
module bucket_count_and_scatter_index_top #(
  parameter int MAX_CLUSTERS = bcsi_pkg::MAX_CLUSTERS_DEF,
  parameter int MAX_VECTORS  = bcsi_pkg::MAX_VECTORS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_wr_en,
  input  logic [bcsi_pkg::CFG_W-1:0]           cfg_wr_data,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [bcsi_pkg::KIND_W-1:0]          in_kind,
  input  logic signed [bcsi_pkg::LABEL_W-1:0]  in_label,
  input  logic [bcsi_pkg::CID_W-1:0]           in_cluster_id,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [bcsi_pkg::STATUS_W-1:0]        out_status,
  output logic [bcsi_pkg::ROW_W-1:0]           out_dest_row,
  output logic [bcsi_pkg::START_W-1:0]         out_bucket_base,
  output logic [bcsi_pkg::COUNT_W-1:0]         out_member_count
);

  // command and status between the sequencer and the table datapath
  bcsi_pkg::cmd_t cmd;
  bcsi_pkg::sts_t sts;

  // sequencer: init sweep, clear sweep, prefix pass, table access, result hand-off
  bcsi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .out_stall (out_stall),
    .sts       (sts),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // histogram, start and cursor tables plus the result register
  bcsi_dp #(
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .MAX_VECTORS  (MAX_VECTORS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_kind          (in_kind),
    .in_label         (in_label),
    .in_cluster_id    (in_cluster_id),
    .out_status       (out_status),
    .out_dest_row     (out_dest_row),
    .out_bucket_base  (out_bucket_base),
    .out_member_count (out_member_count)
  );

endmodule

### verif/bucket_scatter_checker.sv
`timescale 1ns / 1ps

module bucket_scatter_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [bcsi_pkg::CFG_W-1:0]          cfg_wr_data,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [bcsi_pkg::KIND_W-1:0]         in_kind,
  input  logic signed [bcsi_pkg::LABEL_W-1:0] in_label,
  input  logic [bcsi_pkg::CID_W-1:0]          in_cluster_id,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [bcsi_pkg::STATUS_W-1:0]       out_status,
  input  logic [bcsi_pkg::ROW_W-1:0]          out_dest_row,
  input  logic [bcsi_pkg::START_W-1:0]        out_bucket_base,
  input  logic [bcsi_pkg::COUNT_W-1:0]        out_member_count,
  output int unsigned                         mismatch_count,
  output int unsigned                         pending_results
);

  typedef struct packed {
    logic [bcsi_pkg::STATUS_W-1:0] status;
    logic [bcsi_pkg::ROW_W-1:0]    dest_row;
    logic [bcsi_pkg::START_W-1:0]  bucket_base;
    logic [bcsi_pkg::COUNT_W-1:0]  member_count;
  } scatter_result_t;

  logic [bcsi_pkg::CFG_W-1:0]   cluster_limit;
  logic [bcsi_pkg::COUNT_W-1:0] member_hist [bcsi_pkg::MAX_CLUSTERS_DEF];
  logic [bcsi_pkg::START_W-1:0] first_row   [bcsi_pkg::MAX_CLUSTERS_DEF];
  logic [bcsi_pkg::START_W-1:0] next_row    [bcsi_pkg::MAX_CLUSTERS_DEF];
  bit                           offsets_built;

  scatter_result_t expected_results [$];

  function automatic void clear_tables();
    foreach (member_hist[k]) begin
      member_hist[k] = '0;
      first_row[k]   = '0;
      next_row[k]    = '0;
    end
    offsets_built = 1'b0;
  endfunction

  // exclusive prefix sum, running offset saturates at the row limit
  function automatic void build_offsets();
    int unsigned run;
    run = 0;
    for (int k = 0; k < bcsi_pkg::MAX_CLUSTERS_DEF; k++) begin
      first_row[k] = bcsi_pkg::START_W'(run);
      next_row[k]  = bcsi_pkg::START_W'(run);
      if (member_hist[k] >= bcsi_pkg::MAX_VECTORS_DEF - run) run = bcsi_pkg::MAX_VECTORS_DEF;
      else run = run + member_hist[k];
    end
    offsets_built = 1'b1;
  endfunction

  function automatic scatter_result_t predict_scatter_result(
    input logic [bcsi_pkg::KIND_W-1:0]         kind,
    input logic signed [bcsi_pkg::LABEL_W-1:0] label,
    input logic [bcsi_pkg::CID_W-1:0]          cid
  );
    scatter_result_t res;
    int unsigned     limit;
    int unsigned     idx;
    bit              label_ok;
    res      = '0;
    limit    = (cluster_limit > bcsi_pkg::MAX_CLUSTERS_DEF) ? bcsi_pkg::MAX_CLUSTERS_DEF
                                                            : cluster_limit;
    label_ok = (label >= 0) && (int'(label) < limit);
    idx      = label_ok ? int'(label) : 0;
    unique case (kind)
      bcsi_pkg::KIND_COUNT: begin
        if (!label_ok) res.status = bcsi_pkg::ST_RANGE;
        else if (member_hist[idx] >= bcsi_pkg::MAX_VECTORS_DEF) res.status = bcsi_pkg::ST_SAT;
        else member_hist[idx] = member_hist[idx] + 1'b1;
      end
      bcsi_pkg::KIND_PLACE: begin
        if (!offsets_built) build_offsets();
        if (!label_ok) res.status = bcsi_pkg::ST_RANGE;
        else if (next_row[idx] >= bcsi_pkg::MAX_VECTORS_DEF) res.status = bcsi_pkg::ST_SAT;
        else begin
          res.dest_row  = next_row[idx][bcsi_pkg::ROW_W-1:0];
          next_row[idx] = next_row[idx] + 1'b1;
        end
      end
      bcsi_pkg::KIND_READ: begin
        if (cid >= limit) res.status = bcsi_pkg::ST_RANGE;
        else begin
          res.bucket_base  = first_row[cid];
          res.member_count = member_hist[cid];
        end
      end
      bcsi_pkg::KIND_CLEAR: clear_tables();
    endcase
    return res;
  endfunction

  function automatic void note_mismatch(input string what, input scatter_result_t want,
                                        input scatter_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $write("%0t: %s: expected status %0d row %0d base %0d count %0d, ",
             $realtime, what, want.status, want.dest_row, want.bucket_base,
             want.member_count);
      $display("got status %0d row %0d base %0d count %0d",
               got.status, got.dest_row, got.bucket_base, got.member_count);
    end
  endfunction

  always @(posedge clk) begin
    scatter_result_t want;
    scatter_result_t got;
    if (!rst_n) begin
      cluster_limit  = bcsi_pkg::CFG_RESET;
      mismatch_count = 0;
      clear_tables();
      expected_results.delete();
    end else begin
      if (cfg_wr_en) cluster_limit = cfg_wr_data;
      if (in_valid && !in_stall)
        expected_results.push_back(predict_scatter_result(in_kind, in_label, in_cluster_id));
      if (out_valid && !out_stall) begin
        got = '{out_status, out_dest_row, out_bucket_base, out_member_count};
        if (expected_results.size() == 0) begin
          note_mismatch("result with no request outstanding", '0, got);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.dest_row !== want.dest_row ||
              got.bucket_base !== want.bucket_base ||
              got.member_count !== want.member_count)
            note_mismatch("result mismatch", want, got);
        end
      end
    end
    pending_results <= expected_results.size();
  end

endmodule

### verif/bucket_count_and_scatter_index_top_tb.sv
`timescale 1ns / 1ps

module bucket_count_and_scatter_index_top_tb;

  // how long the receiver holds off to back the block up
  localparam int LONG_HOLD = 200;

  logic                                 clk;
  logic                                 rst_n         = 1'b0;
  logic                                 cfg_wr_en     = 1'b0;
  logic [bcsi_pkg::CFG_W-1:0]           cfg_wr_data   = '0;
  logic                                 in_valid      = 1'b0;
  logic                                 in_stall;
  logic [bcsi_pkg::KIND_W-1:0]          in_kind       = bcsi_pkg::KIND_COUNT;
  logic signed [bcsi_pkg::LABEL_W-1:0]  in_label      = '0;
  logic [bcsi_pkg::CID_W-1:0]           in_cluster_id = '0;
  logic                                 out_valid;
  logic                                 out_stall     = 1'b0;
  logic [bcsi_pkg::STATUS_W-1:0]        out_status;
  logic [bcsi_pkg::ROW_W-1:0]           out_dest_row;
  logic [bcsi_pkg::START_W-1:0]         out_bucket_base;
  logic [bcsi_pkg::COUNT_W-1:0]         out_member_count;

  int unsigned mismatch_total;
  int unsigned pending_results;

  // idling rates in percent, set per phase
  int          send_idle_pct  = 0;
  int          recv_idle_pct  = 0;
  // effective cluster count as last programmed, steers label choice
  int          live_clusters  = bcsi_pkg::MAX_CLUSTERS_DEF;
  int unsigned requests_sent  = 0;
  // toggled to ask the receiver for one long hold-off
  bit          hold_req       = 1'b0;

  bucket_count_and_scatter_index_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_label         (in_label),
    .in_cluster_id    (in_cluster_id),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_dest_row     (out_dest_row),
    .out_bucket_base  (out_bucket_base),
    .out_member_count (out_member_count)
  );

  bucket_scatter_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_label         (in_label),
    .in_cluster_id    (in_cluster_id),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_dest_row     (out_dest_row),
    .out_bucket_base  (out_bucket_base),
    .out_member_count (out_member_count),
    .mismatch_count   (mismatch_total),
    .pending_results  (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_receiver
    bit hold_seen;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_stall <= 1'b1;
        // counted here so the sender keeps pushing requests meanwhile
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_stall <= (recv_idle_pct != 0) && ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // any 11-bit label, negatives included
  function automatic int any_label();
    return int'($urandom_range(0, 2047)) - 1024;
  endfunction

  function automatic int any_cid();
    return $urandom_range(0, 255);
  endfunction

  // mostly labels in range, some just past the top, the rest anywhere
  function automatic int pick_label(input int valid_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (live_clusters != 0 && roll < valid_pct) return $urandom_range(0, live_clusters - 1);
    if (roll < valid_pct + 5) return live_clusters + int'($urandom_range(0, 2));
    return any_label();
  endfunction

  function automatic int pick_cid();
    if (live_clusters != 0 && $urandom_range(0, 99) < 80)
      return $urandom_range(0, live_clusters - 1);
    return any_cid();
  endfunction

  // offer one request and hold it until it is taken
  task automatic send_request(input logic [bcsi_pkg::KIND_W-1:0] kind, input int lab,
                              input int cid);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_label      <= bcsi_pkg::LABEL_W'(lab);
    in_cluster_id <= bcsi_pkg::CID_W'(cid);
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  // stop offering and wait for every outstanding result to come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  // only called once the block is drained
  task automatic write_clusters(input int value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= bcsi_pkg::CFG_W'(value);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    live_clusters = (value > bcsi_pkg::MAX_CLUSTERS_DEF) ? bcsi_pkg::MAX_CLUSTERS_DEF : value;
  endtask

  // one sort job: clear, histogram, reads, scatter, late counts, reads, a little noise
  task automatic run_scatter_job();
    int n_count;
    int n_place;
    n_count = $urandom_range(3, 40);
    n_place = $urandom_range(n_count / 2, n_count + 4);
    // now and then carry on from the tables left by the previous job
    if ($urandom_range(0, 3) != 0) send_request(bcsi_pkg::KIND_CLEAR, any_label(), any_cid());
    repeat (n_count) send_request(bcsi_pkg::KIND_COUNT, pick_label(85), any_cid());
    repeat ($urandom_range(0, 3)) send_request(bcsi_pkg::KIND_READ, any_label(), pick_cid());
    repeat (n_place) send_request(bcsi_pkg::KIND_PLACE, pick_label(85), any_cid());
    // counts once placing has started leave the offsets frozen
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 5))
        send_request(bcsi_pkg::KIND_COUNT, pick_label(85), any_cid());
    repeat ($urandom_range(1, 6)) send_request(bcsi_pkg::KIND_READ, any_label(), pick_cid());
    repeat ($urandom_range(0, 4))
      send_request(bcsi_pkg::KIND_W'($urandom_range(0, 3)), any_label(), any_cid());
  endtask

  task automatic run_random_phase(input int sender_pct, input int receiver_pct,
                                  input int clusters, input int items, input bit squeeze);
    int unsigned phase_start;
    write_clusters(clusters);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    phase_start   = requests_sent;
    if (squeeze) hold_req <= ~hold_req;
    while (requests_sent - phase_start < items) run_scatter_job();
    drain_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: default cluster count, reads before any prefix pass
    send_request(bcsi_pkg::KIND_READ, 0, 0);
    send_request(bcsi_pkg::KIND_COUNT, 0, 0);
    send_request(bcsi_pkg::KIND_COUNT, bcsi_pkg::MAX_CLUSTERS_DEF - 1, 0);
    send_request(bcsi_pkg::KIND_COUNT, bcsi_pkg::MAX_CLUSTERS_DEF, 0);
    send_request(bcsi_pkg::KIND_COUNT, -1, 0);
    send_request(bcsi_pkg::KIND_COUNT, -1024, 0);
    send_request(bcsi_pkg::KIND_COUNT, 1023, 0);
    send_request(bcsi_pkg::KIND_COUNT, 0, 0);
    send_request(bcsi_pkg::KIND_READ, 0, bcsi_pkg::MAX_CLUSTERS_DEF - 1);
    // first place runs the prefix pass
    send_request(bcsi_pkg::KIND_PLACE, 0, 0);
    send_request(bcsi_pkg::KIND_PLACE, 0, 0);
    send_request(bcsi_pkg::KIND_PLACE, 0, 0);
    send_request(bcsi_pkg::KIND_PLACE, bcsi_pkg::MAX_CLUSTERS_DEF - 1, 0);
    send_request(bcsi_pkg::KIND_PLACE, -5, 0);
    // late count: histogram moves, starts stay put
    send_request(bcsi_pkg::KIND_COUNT, 5, 0);
    send_request(bcsi_pkg::KIND_READ, 0, 5);
    send_request(bcsi_pkg::KIND_READ, 0, bcsi_pkg::MAX_CLUSTERS_DEF - 1);
    send_request(bcsi_pkg::KIND_CLEAR, 0, 0);
    send_request(bcsi_pkg::KIND_PLACE, 7, 0);
    send_request(bcsi_pkg::KIND_READ, 0, 7);
    drain_results();

    // no clusters at all: everything out of range
    write_clusters(0);
    send_request(bcsi_pkg::KIND_COUNT, 0, 0);
    send_request(bcsi_pkg::KIND_READ, 0, 0);
    send_request(bcsi_pkg::KIND_PLACE, 0, 0);
    drain_results();

    // single cluster
    write_clusters(1);
    send_request(bcsi_pkg::KIND_COUNT, 0, 0);
    send_request(bcsi_pkg::KIND_COUNT, 1, 0);
    send_request(bcsi_pkg::KIND_READ, 0, 0);
    send_request(bcsi_pkg::KIND_READ, 0, 1);
    send_request(bcsi_pkg::KIND_READ, 0, bcsi_pkg::MAX_CLUSTERS_DEF - 1);
    drain_results();

    // register above the table size acts as the full table
    write_clusters(511);
    send_request(bcsi_pkg::KIND_READ, 0, bcsi_pkg::MAX_CLUSTERS_DEF - 1);
    send_request(bcsi_pkg::KIND_COUNT, bcsi_pkg::MAX_CLUSTERS_DEF - 1, 0);
    send_request(bcsi_pkg::KIND_COUNT, bcsi_pkg::MAX_CLUSTERS_DEF, 0);
    drain_results();

    // random jobs: sender light, receiver heavy, with a long back-up
    run_random_phase(20, 53, 6, 400, 1'b1);
    // sender heavy, receiver light, full table
    run_random_phase(53, 20, bcsi_pkg::MAX_CLUSTERS_DEF, 400, 1'b0);
    // back to back in both directions, random small table
    run_random_phase(0, 0, $urandom_range(2, 24), 400, 1'b0);

    // let any stray result show up before the verdict
    repeat (bcsi_pkg::MAX_CLUSTERS_DEF + 16) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("bucket_count_and_scatter_index_top_tb passed");
    end else begin
      $display("bucket_count_and_scatter_index_top_tb failed");
    end
    $finish;
  end

  // overall limit, well beyond the slowest correct run
  initial begin
    #8_000_000;
    $display("bucket_count_and_scatter_index_top_tb failed");
    $finish;
  end

endmodule
